>>> rtl/core/tmhc_pkg.sv
// Package for the tempo median hysteresis classifier.
// Holds shared types, register indexes, reset values and level codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tmhc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BEATS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HYST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_IV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_IV  = 3'd5;

	localparam logic [3:0]  RST_BEATS  = 4'd2;
	localparam logic [9:0]  RST_SLOW   = 10'd100;
	localparam logic [9:0]  RST_FAST   = 10'd160;
	localparam logic [5:0]  RST_HYST   = 6'd5;
	localparam logic [15:0] RST_MIN_IV = 16'd100;
	localparam logic [15:0] RST_MAX_IV = 16'd3000;

	// Tempo levels
	localparam logic [1:0] LVL_SLOW   = 2'd0;
	localparam logic [1:0] LVL_NORMAL = 2'd1;
	localparam logic [1:0] LVL_FAST   = 2'd2;

	// Arithmetic
	localparam int BPM_W   = 20;
	localparam int NUM_W   = 24;   // holds 15 * 60000 * 16
	localparam int THR_W   = 12;   // signed whole-BPM threshold after hysteresis
	localparam int CNT_W   = 5;    // step counter: sort passes, shift steps and quotient bits
	localparam int SHIFT_W = 4;    // median select shift, window of at most 15
	localparam logic [NUM_W-1:0] MS_Q4_PER_MIN = 24'd960000;

	typedef struct packed {
		logic [3:0]  beats;
		logic [9:0]  slow;
		logic [9:0]  fast;
		logic [5:0]  hyst;
		logic [15:0] min_iv;
		logic [15:0] max_iv;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic reject;
		logic write;
		logic load;
		logic sort;
		logic phase;
		logic shift;
		logic median;
		logic div;
		logic classify;
		logic publish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic               restart;
		logic               in_range;
		logic [SHIFT_W-1:0] med_shift;
	} sts_t;

	typedef struct packed {
		logic             accepted;
		logic [BPM_W-1:0] bpm_q4;
		logic [1:0]       tempo_level;
		logic             level_changed;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/tmhc_ifs.sv
// Valid/ready channel interfaces for the tempo classifier.
// One interface for interval beats, one for result beats; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tmhc_in_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [15:0] interval_ms;

	modport source (output valid, output restart, output interval_ms, input ready);
	modport sink   (input valid, input restart, input interval_ms, output ready);
endinterface

interface tmhc_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [19:0] bpm_q4;
	logic [1:0]  tempo_level;
	logic        level_changed;

	modport source (output valid, output accepted, output bpm_q4, output tempo_level,
		output level_changed, input ready);
	modport sink   (input valid, input accepted, input bpm_q4, input tempo_level,
		input level_changed, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tmhc_ctrl.sv
// Sequencing controller for the tempo classifier.
// Uses tmhc_pkg; drives datapath commands and the channel handshakes.
`timescale 1ns / 1ps
`default_nettype none

module tmhc_ctrl #(
	parameter int WINDOW = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire tmhc_pkg::sts_t sts,
	output tmhc_pkg::cmd_t     cmd
);
	import tmhc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_LOAD   = 4'd2;
	localparam logic [3:0] ST_SORT   = 4'd3;
	localparam logic [3:0] ST_SHIFT  = 4'd4;
	localparam logic [3:0] ST_MEDIAN = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_CLASS  = 4'd7;
	localparam logic [3:0] ST_FINISH = 4'd8;

	logic [3:0]       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             out_vld_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.restart) begin
					cmd.clear = 1'b1;
					state_nxt = ST_FINISH;
				end else if (!sts.in_range) begin
					cmd.reject = 1'b1;
					state_nxt  = ST_FINISH;
				end else begin
					cmd.write = 1'b1;
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				cnt_nxt   = '0;
				state_nxt = ST_SORT;
			end
			ST_SORT: begin
				cmd.sort  = 1'b1;
				cmd.phase = cnt_q[0];
				if (cnt_q == CNT_W'(WINDOW - 1)) begin
					cnt_nxt   = '0;
					state_nxt = ST_SHIFT;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_SHIFT: begin
				if (cnt_q == CNT_W'(sts.med_shift)) begin
					state_nxt = ST_MEDIAN;
				end else begin
					cmd.shift = 1'b1;
					cnt_nxt   = cnt_q + 1'b1;
				end
			end
			ST_MEDIAN: begin
				cmd.median = 1'b1;
				cnt_nxt    = '0;
				state_nxt  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_nxt = ST_CLASS;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_nxt    = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_vld_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (cmd.publish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;

endmodule

`default_nettype wire

>>> rtl/core/tmhc_dp.sv
// Datapath for the tempo classifier: window, sorter, divider, classifier.
// Uses tmhc_pkg; steered by tmhc_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module tmhc_dp #(
	parameter int WINDOW        = 3,
	parameter int INTERVAL_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          restart,
	input  wire logic [15:0]   interval_ms,
	input  wire tmhc_pkg::cfg_t cfg,
	input  wire tmhc_pkg::cmd_t cmd,
	output tmhc_pkg::sts_t     sts,
	output tmhc_pkg::result_t  res
);
	import tmhc_pkg::*;

	localparam int IW   = (INTERVAL_BITS < 16) ? INTERVAL_BITS : 16;
	localparam int SW   = IW + 1;                 // top bit marks an empty slot
	localparam int PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW   = $clog2(WINDOW + 1);
	localparam int IDX1 = (WINDOW > 1) ? 1 : 0;
	localparam logic [SW-1:0] EMPTY = {1'b1, {IW{1'b0}}};

	logic             rst_q;
	logic [IW-1:0]    iv_q;
	logic [IW-1:0]    win_q [WINDOW];
	logic [SW-1:0]    srt_q [WINDOW];
	logic [SW-1:0]    srt_nxt [WINDOW];
	logic [PW-1:0]    ptr_q;
	logic [FW-1:0]    fill_q;
	logic [IW-1:0]    div_q;
	logic [IW-1:0]    rem_q;
	logic [NUM_W-1:0] num_q;
	logic [BPM_W-1:0] bpm_q;
	logic [1:0]       lvl_q;
	logic             lvl_vld_q;
	logic             acc_q;
	logic             chg_q;
	result_t          res_q;

	// Range check
	logic [15:0] iv16;
	assign iv16 = 16'(iv_q);

	assign sts.restart   = rst_q;
	assign sts.in_range  = (iv16 != 16'd0) && (iv16 >= cfg.min_iv) && (iv16 <= cfg.max_iv);
	assign sts.med_shift = SHIFT_W'(FW'(fill_q - FW'(1)) >> 1);

	// One odd-even transposition pass: pairs are disjoint within a phase
	always_comb begin
		srt_nxt = srt_q;
		for (int i = 0; i + 1 < WINDOW; i++) begin
			if ((i[0] == cmd.phase) && (srt_q[i] > srt_q[i+1])) begin
				srt_nxt[i]   = srt_q[i+1];
				srt_nxt[i+1] = srt_q[i];
			end
		end
	end

	// Median of the leading entries after the select shift
	logic [IW:0]   med_sum;
	logic [IW-1:0] med_raw;
	logic [IW-1:0] med;
	assign med_sum = {1'b0, srt_q[0][IW-1:0]} + {1'b0, srt_q[IDX1][IW-1:0]};
	assign med_raw = fill_q[0] ? srt_q[0][IW-1:0] : med_sum[IW:1];
	assign med     = (med_raw == '0) ? IW'(1) : med_raw;

	// Restoring divider step
	logic [IW:0] trial;
	logic [IW:0] diff;
	logic        ge;
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	// Saturate and classify
	logic [BPM_W-1:0] sat;
	logic [THR_W-1:0] slow12, fast12, h12, lo, hi;
	logic [BPM_W:0]   b21, lo21, hi21;
	logic [1:0]       new_lvl;
	assign sat    = (|num_q[NUM_W-1:BPM_W]) ? '1 : num_q[BPM_W-1:0];
	assign slow12 = THR_W'(cfg.slow);
	assign fast12 = THR_W'(cfg.fast);
	assign h12    = THR_W'(cfg.hyst);

	always_comb begin
		lo = slow12;
		hi = fast12;
		if (lvl_vld_q) begin
			lo = (lvl_q == LVL_SLOW) ? slow12 + h12 : slow12 - h12;
			hi = (lvl_q == LVL_FAST) ? fast12 - h12 : fast12 + h12;
		end
	end

	assign b21  = {1'b0, sat};
	assign lo21 = {{(BPM_W + 1 - THR_W - 4){lo[THR_W-1]}}, lo, 4'b0000};
	assign hi21 = {{(BPM_W + 1 - THR_W - 4){hi[THR_W-1]}}, hi, 4'b0000};

	always_comb begin
		if ($signed(b21) < $signed(lo21)) begin
			new_lvl = LVL_SLOW;
		end else if ($signed(b21) >= $signed(hi21)) begin
			new_lvl = LVL_FAST;
		end else begin
			new_lvl = LVL_NORMAL;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rst_q <= restart;
			iv_q  <= interval_ms[IW-1:0];
		end
		if (cmd.write) begin
			win_q[ptr_q] <= iv_q;
		end
		if (cmd.load) begin
			for (int i = 0; i < WINDOW; i++) begin
				srt_q[i] <= (FW'(i) < fill_q) ? {1'b0, win_q[i]} : EMPTY;
			end
		end else if (cmd.sort) begin
			srt_q <= srt_nxt;
		end else if (cmd.shift) begin
			for (int i = 0; i + 1 < WINDOW; i++) begin
				srt_q[i] <= srt_q[i+1];
			end
			srt_q[WINDOW-1] <= EMPTY;
		end
		if (cmd.median) begin
			div_q <= med;
			rem_q <= '0;
			num_q <= NUM_W'(cfg.beats) * MS_Q4_PER_MIN;
		end else if (cmd.div) begin
			rem_q <= ge ? diff[IW-1:0] : trial[IW-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
		if (cmd.publish) begin
			res_q.accepted      <= acc_q;
			res_q.bpm_q4        <= bpm_q;
			res_q.tempo_level   <= lvl_q;
			res_q.level_changed <= chg_q;
		end
	end

	// Tempo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			fill_q    <= '0;
			bpm_q     <= '0;
			lvl_q     <= LVL_NORMAL;
			lvl_vld_q <= 1'b0;
			acc_q     <= 1'b0;
			chg_q     <= 1'b0;
		end else begin
			if (cmd.clear) begin
				ptr_q     <= '0;
				fill_q    <= '0;
				bpm_q     <= '0;
				lvl_q     <= LVL_NORMAL;
				lvl_vld_q <= 1'b0;
			end
			if (cmd.clear || cmd.reject) begin
				acc_q <= 1'b0;
				chg_q <= 1'b0;
			end
			if (cmd.write) begin
				ptr_q <= (ptr_q == PW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != FW'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.classify) begin
				bpm_q     <= sat;
				lvl_q     <= new_lvl;
				lvl_vld_q <= 1'b1;
				acc_q     <= 1'b1;
				chg_q     <= !lvl_vld_q || (new_lvl != lvl_q);
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

>>> rtl/core/tempo_median_hysteresis_classifier.sv
// Top level of the tempo median hysteresis classifier.
// Depends on tmhc_pkg, tmhc_ifs, tmhc_ctrl and tmhc_dp.
//
// Usage:
//   in_ch carries one beat per item: restart and interval_ms (ms between beats).
//   out_ch returns one beat per input item: accepted, bpm_q4 (BPM, 4 fraction
//   bits, saturated at 20 bits), tempo_level (slow, normal, fast) and
//   level_changed.
//   The user must write the configuration registers through cfg_we / cfg_index /
//   cfg_wdata, one register per cycle, only while the block is idle; the block
//   does not enforce it. Unknown indexes and a zero beats value are dropped.
// Sequence:
//   A restart or an out-of-range interval goes from the check to the output slot.
//   An accepted interval runs WINDOW sort passes, a short shift to line up the
//   median, and 24 steps of the serial divider, and is then classified.
//   One item is in flight at a time; in_ch.ready is high only when idle.
// Reset and stall:
//   arst_n clears the window, level and flags and loads the register defaults.
//   The result sits in an output register; a stalled receiver holds the beat,
//   and the next item can be worked on meanwhile but waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module tempo_median_hysteresis_classifier #(
	parameter int WINDOW        = 3,
	parameter int INTERVAL_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	tmhc_in_if.sink                                  in_ch,
	tmhc_out_if.source                               out_ch,
	input  wire logic                                cfg_we,
	input  wire logic [tmhc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tmhc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tmhc_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	sts_t    sts;
	result_t res;
	logic    in_ready;
	logic    out_valid;

	// Configuration registers; hold their value on a write to an unknown index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beats  <= RST_BEATS;
			cfg_q.slow   <= RST_SLOW;
			cfg_q.fast   <= RST_FAST;
			cfg_q.hyst   <= RST_HYST;
			cfg_q.min_iv <= RST_MIN_IV;
			cfg_q.max_iv <= RST_MAX_IV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BEATS: begin
					// zero beats would null the tempo: drop it
					if (cfg_wdata[3:0] != 4'd0) begin
						cfg_q.beats <= cfg_wdata[3:0];
					end
				end
				REG_SLOW:   cfg_q.slow   <= cfg_wdata[9:0];
				REG_FAST:   cfg_q.fast   <= cfg_wdata[9:0];
				REG_HYST:   cfg_q.hyst   <= cfg_wdata[5:0];
				REG_MIN_IV: cfg_q.min_iv <= cfg_wdata[15:0];
				REG_MAX_IV: cfg_q.max_iv <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: walks check, sort, median select, divide and classify
	tmhc_ctrl #(
		.WINDOW (WINDOW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Window, sorter, divider, classifier and result register
	tmhc_dp #(
		.WINDOW        (WINDOW),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (in_ch.restart),
		.interval_ms (in_ch.interval_ms),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.res         (res)
	);

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid;
	assign out_ch.accepted      = res.accepted;
	assign out_ch.bpm_q4        = res.bpm_q4;
	assign out_ch.tempo_level   = res.tempo_level;
	assign out_ch.level_changed = res.level_changed;

	// One item in flight: accepting a beat closes the input until it is done
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while an item is in flight");

	// Only a used interval can set or change the level
	a_change_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.level_changed |-> out_ch.accepted)
		else $error("level change reported on an unused interval");

	// Any used interval gives a nonzero tempo
	a_bpm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.accepted |-> out_ch.bpm_q4 != 20'd0)
		else $error("zero tempo on an accepted interval");

endmodule

`default_nettype wire
